### src/qe_pkg.sv
// Shared types, constants and the arctangent table for the quaternion-to-Euler pipeline.
package qe_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;
   localparam int CORDIC_N      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

   localparam int QW        = 16;  // quaternion part / angle width
   localparam int PW        = 34;  // width of the doubled product sums
   localparam int SW        = 30;  // clamped asin argument
   localparam int RW        = 57;  // radicand for the cosine square root
   localparam int ISQ_BITS  = 29;  // root bits, one per stage
   localparam int CW        = 37;  // CORDIC x/y datapath
   localparam int ZW        = 25;  // CORDIC angle accumulator, 2^-20 rad
   localparam int FRONT_LAT = 4;
   localparam int CORDIC_LAT = CORDIC_N + 2;
   localparam int PIPE_LAT  = FRONT_LAT + ISQ_BITS + CORDIC_LAT;

   localparam logic signed [ZW-1:0] PI_FINE     = ZW'(3294199);
   localparam logic signed [ZW-1:0] TWO_PI_FINE = ZW'(6588398);
   localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
   localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;
   localparam logic signed [17:0]   TWO_PI_Q13  = 18'sd51472;
   localparam logic signed [PW-1:0] ONE_Q28     = PW'(64'sd268435456);
   localparam logic signed [SW-1:0] S_MAX       = SW'(64'sd268435456);
   localparam logic [RW-1:0]        ONE_Q56     = RW'(1) << 56;

   typedef struct packed {
      logic signed [PW-1:0] rn;
      logic signed [PW-1:0] rd;
      logic signed [PW-1:0] yn;
      logic signed [PW-1:0] yd;
      logic signed [SW-1:0] s;
      logic signed [QW-1:0] h;
   } qe_ops_type;

   function automatic logic signed [ZW-1:0] atan_fine(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0: v = ZW'(823550);
         1: v = ZW'(486170);
         2: v = ZW'(256879);
         3: v = ZW'(130396);
         4: v = ZW'(65451);
         5: v = ZW'(32757);
         6: v = ZW'(16383);
         7: v = ZW'(8192);
         8: v = ZW'(4096);
         9: v = ZW'(2048);
         10: v = ZW'(1024);
         11: v = ZW'(512);
         12: v = ZW'(256);
         13: v = ZW'(128);
         14: v = ZW'(64);
         15: v = ZW'(32);
         16: v = ZW'(16);
         17: v = ZW'(8);
         18: v = ZW'(4);
         19: v = ZW'(2);
         20: v = ZW'(1);
         21: v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### src/qe_front.sv
// Front end: quaternion products, atan2/asin operands, s squared and the sqrt radicand.
module qe_front import qe_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [QW-1:0] quat_w,
   input  logic signed [QW-1:0] quat_x,
   input  logic signed [QW-1:0] quat_y,
   input  logic signed [QW-1:0] quat_z,
   input  logic signed [QW-1:0] heading_angle,
   output qe_ops_type           ops,
   output logic [RW-1:0]        rad
);
   logic signed [31:0] zy_ff, wx_ff, yw_ff, zx_ff, zw_ff, xy_ff, ww_ff, xx_ff, yy_ff;
   logic signed [QW-1:0] h1_ff;
   qe_ops_type ops2_ff, ops3_ff, ops4_ff, ops2_in;
   logic [RW-1:0] sq3_ff, rad4_ff;
   logic signed [PW-1:0] s_wide;
   logic signed [2*SW-1:0] sq_full;

   always_ff @(posedge clock) begin
      if (en) begin
         zy_ff <= quat_z * quat_y;
         wx_ff <= quat_w * quat_x;
         yw_ff <= quat_y * quat_w;
         zx_ff <= quat_z * quat_x;
         zw_ff <= quat_z * quat_w;
         xy_ff <= quat_x * quat_y;
         ww_ff <= quat_w * quat_w;
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         h1_ff <= heading_angle;
      end
   end

   always_comb begin
      ops2_in.rn = (PW'(zy_ff) + PW'(wx_ff)) <<< 1;
      ops2_in.rd = ONE_Q28 - ((PW'(xx_ff) + PW'(yy_ff)) <<< 1);
      ops2_in.yn = (PW'(zw_ff) + PW'(xy_ff)) <<< 1;
      ops2_in.yd = ((PW'(ww_ff) + PW'(xx_ff)) <<< 1) - ONE_Q28;
      s_wide     = (PW'(yw_ff) - PW'(zx_ff)) <<< 1;
      if (s_wide > PW'(S_MAX))       ops2_in.s = S_MAX;
      else if (s_wide < -PW'(S_MAX)) ops2_in.s = -S_MAX;
      else                           ops2_in.s = s_wide[SW-1:0];
      if (h1_ff > PI_Q13)       ops2_in.h = PI_Q13;
      else if (h1_ff < -PI_Q13) ops2_in.h = -PI_Q13;
      else                      ops2_in.h = h1_ff;
   end

   assign sq_full = ops2_ff.s * ops2_ff.s;

   always_ff @(posedge clock) begin
      if (en) begin
         ops2_ff <= ops2_in;
         ops3_ff <= ops2_ff;
         sq3_ff  <= sq_full[RW-1:0];
         ops4_ff <= ops3_ff;
         rad4_ff <= ONE_Q56 - sq3_ff;
      end
   end

   assign ops = ops4_ff;
   assign rad = rad4_ff;
endmodule

### src/qe_isqrt.sv
// Pipelined floor square root, one root bit per stage.
module qe_isqrt import qe_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [RW-1:0]       rad,
   output logic [ISQ_BITS-1:0] root
);
   logic [RW-1:0]       rem_ff  [1:ISQ_BITS];
   logic [ISQ_BITS-1:0] root_ff [1:ISQ_BITS];

   for (genvar k = 0; k < ISQ_BITS; k++) begin : g_stage
      localparam int B = ISQ_BITS - 1 - k;
      logic [RW:0]         trial;
      logic [RW-1:0]       rem_cur;
      logic [ISQ_BITS-1:0] root_cur;
      if (k == 0) begin : g_first
         assign rem_cur  = rad;
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[k];
         assign root_cur = root_ff[k];
      end
      // (2*root + 2^B) * 2^B, root holds only bits above B
      assign trial = ((RW+1)'(root_cur) << (B + 1)) | ((RW+1)'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (en) begin
            if ({1'b0, rem_cur} >= trial) begin
               rem_ff[k+1]  <= rem_cur - trial[RW-1:0];
               root_ff[k+1] <= root_cur | (ISQ_BITS'(1) << B);
            end else begin
               rem_ff[k+1]  <= rem_cur;
               root_ff[k+1] <= root_cur;
            end
         end
      end
   end

   assign root = root_ff[ISQ_BITS];
endmodule

### src/qe_cordic.sv
// Pipelined vectoring CORDIC atan2 with quadrant fold, wrap, rounding and clamp to Q3.13.
module qe_cordic import qe_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] y_in,
   input  logic signed [CW-1:0] x_in,
   output logic signed [QW-1:0] angle
);
   logic signed [CW-1:0] x_ff [0:CORDIC_N];
   logic signed [CW-1:0] y_ff [0:CORDIC_N];
   logic signed [ZW-1:0] z_ff [0:CORDIC_N];
   logic                 zero_ff [0:CORDIC_N];
   logic signed [ZW-1:0] zw;
   logic signed [17:0]   q;
   logic signed [QW-1:0] angle_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            z_ff[0] <= (y_in >= 0) ? PI_FINE : -PI_FINE;
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_fine(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_fine(i);
            end
         end
      end
   end

   always_comb begin
      zw = z_ff[CORDIC_N];
      if (zw > PI_FINE)       zw = zw - TWO_PI_FINE;
      else if (zw < -PI_FINE) zw = zw + TWO_PI_FINE;
      q = 18'((zw + ZW'(64)) >>> 7);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[CORDIC_N])      angle_ff <= '0;
         else if (q > 18'(PI_Q13))   angle_ff <= PI_Q13;
         else if (q < -18'(PI_Q13))  angle_ff <= -PI_Q13;
         else                        angle_ff <= q[QW-1:0];
      end
   end

   assign angle = angle_ff;
endmodule

### src/quaternion_to_euler_yaw_frame.sv
// Top level: quaternion to roll/pitch/yaw plus heading in body and inertial frames.
//  channel   dir  handshake           payload
//  req_      in   tvalid/tready       w, x, y, z, heading (80-bit tdata)
//  rsp_      out  tvalid/tready       roll, pitch, yaw, to_body, to_inertial (80-bit tdata)
// One transaction per cycle sustained unless the output stalls; the pipeline is 4 front + 29 sqrt +
// CORDIC_N+2 atan2 stages plus the output register.
// Reset clears only valid bits. The whole pipeline holds while a result waits at the
// output register and the last stage is full; bubbles still advance.
module quaternion_to_euler_yaw_frame import qe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48], heading_angle[79:64]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // roll[15:0], pitch[30:16], yaw[46:31], to_body[62:47], to_inertial[78:63], zero[79]
   output logic [79:0] rsp_tdata
);
   logic                en;
   logic                v_ff [0:PIPE_LAT-1];
   qe_ops_type          ops;
   qe_ops_type          d_ff [0:ISQ_BITS-1];
   logic signed [QW-1:0] hd_ff [0:CORDIC_LAT-1];
   logic [RW-1:0]       rad;
   logic [ISQ_BITS-1:0] root;
   logic signed [QW-1:0] roll, pitch, yaw;
   logic signed [16:0]  body_raw, inert_raw;
   logic signed [QW-1:0] body, inert;
   logic signed [14:0]  pitch_c;
   logic                out_valid_ff;
   logic [79:0]         out_data_ff;

   assign en         = !v_ff[PIPE_LAT-1] || !out_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_tvalid;
         for (int i = 1; i < PIPE_LAT; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   qe_front u_front (
      .clock, .en,
      .quat_w(req_tdata[15:0]), .quat_x(req_tdata[31:16]), .quat_y(req_tdata[47:32]),
      .quat_z(req_tdata[63:48]), .heading_angle(req_tdata[79:64]),
      .ops, .rad
   );

   qe_isqrt u_isqrt (.clock, .en, .rad, .root);

   // operands wait beside the square root
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= ops;
         for (int i = 1; i < ISQ_BITS; i++) d_ff[i] <= d_ff[i-1];
         hd_ff[0] <= d_ff[ISQ_BITS-1].h;
         for (int i = 1; i < CORDIC_LAT; i++) hd_ff[i] <= hd_ff[i-1];
      end
   end

   qe_cordic u_roll (
      .clock, .en,
      .y_in(CW'(d_ff[ISQ_BITS-1].rn)), .x_in(CW'(d_ff[ISQ_BITS-1].rd)), .angle(roll)
   );
   qe_cordic u_pitch (
      .clock, .en,
      .y_in(CW'(d_ff[ISQ_BITS-1].s)), .x_in(CW'({1'b0, root})), .angle(pitch)
   );
   qe_cordic u_yaw (
      .clock, .en,
      .y_in(CW'(d_ff[ISQ_BITS-1].yn)), .x_in(CW'(d_ff[ISQ_BITS-1].yd)), .angle(yaw)
   );

   always_comb begin
      body_raw  = 17'(hd_ff[CORDIC_LAT-1]) - 17'(yaw);
      inert_raw = 17'(hd_ff[CORDIC_LAT-1]) + 17'(yaw);
      if (body_raw < -17'(PI_Q13))      body = QW'(body_raw + 17'(TWO_PI_Q13));
      else if (body_raw > 17'(PI_Q13))  body = QW'(body_raw - 17'(TWO_PI_Q13));
      else                              body = body_raw[QW-1:0];
      if (inert_raw < -17'(PI_Q13))     inert = QW'(inert_raw + 17'(TWO_PI_Q13));
      else if (inert_raw > 17'(PI_Q13)) inert = QW'(inert_raw - 17'(TWO_PI_Q13));
      else                              inert = inert_raw[QW-1:0];
      if (pitch > HALF_PI_Q13)       pitch_c = 15'(HALF_PI_Q13);
      else if (pitch < -HALF_PI_Q13) pitch_c = -15'(HALF_PI_Q13);
      else                           pitch_c = pitch[14:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en && v_ff[PIPE_LAT-1]) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && v_ff[PIPE_LAT-1]) begin
         out_data_ff <= {1'b0, inert, body, yaw, pitch_c, roll};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
endmodule

### src/qe_checker.sv
// Port-level checks for the quaternion-to-Euler block, bound to the top level.
module qe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[30:16]) <= 15'sd12868 &&
                     $signed(rsp_tdata[30:16]) >= -15'sd12868)
      else $error("pitch beyond half pi");

   a_frames: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[62:47]) <= 16'sd25736 &&
                     $signed(rsp_tdata[62:47]) >= -16'sd25736 &&
                     $signed(rsp_tdata[78:63]) <= 16'sd25736 &&
                     $signed(rsp_tdata[78:63]) >= -16'sd25736)
      else $error("frame angle not wrapped");
endmodule

bind quaternion_to_euler_yaw_frame qe_checker u_qe_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
